// ===== rtl/segment_sphere_hit_test_core_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef SEGMENT_SPHERE_HIT_TEST_CORE_MACROS_SVH
`define SEGMENT_SPHERE_HIT_TEST_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SSHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/ssht_pkg.sv =====
`timescale 1ns / 1ps

package ssht_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int RADIUS_BITS        = 15;
    localparam int APB_ADDR_BITS      = 5;
    localparam int APB_DATA_BITS      = 32;
    localparam int REG_IDX_LSB        = 2;
    localparam int REG_IDX_BITS       = APB_ADDR_BITS - REG_IDX_LSB;
    localparam int PIPE_STAGES        = 7;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } reg_idx_t;

endpackage

// ===== rtl/segment_sphere_hit_test_core.sv =====
`timescale 1ns / 1ps
// The hit flag is formed through the stage 1 to stage 7 registers and is presented from the stage 7 output register.
// Throughput: one sphere per cycle; seven register stages, each holding one item.
// The pipeline stalls only while the output register holds an untaken result.
// Reset clears the wall endpoint registers to zero and empties the pipeline.
`include "segment_sphere_hit_test_core_macros.svh"

module segment_sphere_hit_test_core
    import ssht_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_BITS-1:0]      paddr,
    input  logic [APB_DATA_BITS-1:0]      pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  centre_x,
    input  logic signed [COORD_BITS-1:0]  centre_y,
    input  logic signed [COORD_BITS-1:0]  centre_z,
    input  logic [RADIUS_BITS-1:0]        sphere_radius,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit
);

    localparam int D   = COORD_BITS + 1;          // coordinate difference
    localparam int P2  = 2 * D;                   // product of two differences
    localparam int S3  = P2 + 2;                  // sum of three products
    localparam int W   = P2;                      // magnitude of a dot product
    localparam int L   = W / 2;                   // limb of the wide multiply
    localparam int RW  = 2 * RADIUS_BITS;         // radius squared
    localparam int WWW = ((W > RW) ? W : RW) + 1; // |P-S|^2 minus radius squared
    localparam int N   = PIPE_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] start_reg [3];
    logic signed [COORD_BITS-1:0] start_next [3];
    logic signed [COORD_BITS-1:0] end_reg [3];
    logic signed [COORD_BITS-1:0] end_next [3];
    logic                         cfg_wr;
    reg_idx_t                     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:REG_IDX_LSB]);

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_START_X: start_next[0] = pwdata[COORD_BITS-1:0];
                REG_START_Y: start_next[1] = pwdata[COORD_BITS-1:0];
                REG_START_Z: start_next[2] = pwdata[COORD_BITS-1:0];
                REG_END_X:   end_next[0]   = pwdata[COORD_BITS-1:0];
                REG_END_Y:   end_next[1]   = pwdata[COORD_BITS-1:0];
                REG_END_Z:   end_next[2]   = pwdata[COORD_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_START_X: prdata = APB_DATA_BITS'(start_reg[0]);
            REG_START_Y: prdata = APB_DATA_BITS'(start_reg[1]);
            REG_START_Z: prdata = APB_DATA_BITS'(start_reg[2]);
            REG_END_X:   prdata = APB_DATA_BITS'(end_reg[0]);
            REG_END_Y:   prdata = APB_DATA_BITS'(end_reg[1]);
            REG_END_Z:   prdata = APB_DATA_BITS'(end_reg[2]);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: stage k loads when it is empty or stage k+1 loads.
    // ------------------------------------------------------------------
    logic [N:1]   v_reg;
    logic [N:1]   v_next;
    logic [N+1:1] adv;

    always_comb
    begin
        adv[N+1] = out_ready;
        for (int k = N; k >= 1; k--)
            adv[k] = !v_reg[k] || adv[k+1];
        v_next = v_reg;
        if (adv[1])
            v_next[1] = in_valid;
        for (int k = 2; k <= N; k++)
            if (adv[k])
                v_next[k] = v_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = adv[1];
    assign out_valid = v_reg[N];

    // ------------------------------------------------------------------
    // Stage 1: differences P-S, E-P and E-S.
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] ctr [3];
    logic signed [D-1:0]          ps1_reg [3];
    logic signed [D-1:0]          ps1_next [3];
    logic signed [D-1:0]          ep1_reg [3];
    logic signed [D-1:0]          ep1_next [3];
    logic signed [D-1:0]          es1_reg [3];
    logic signed [D-1:0]          es1_next [3];
    logic [RADIUS_BITS-1:0]       r1_reg;
    logic [RADIUS_BITS-1:0]       r1_next;

    assign ctr[0] = centre_x;
    assign ctr[1] = centre_y;
    assign ctr[2] = centre_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ps1_next[i] = D'(ctr[i]) - D'(start_reg[i]);
            ep1_next[i] = D'(end_reg[i]) - D'(ctr[i]);
            es1_next[i] = D'(end_reg[i]) - D'(start_reg[i]);
        end
        r1_next = sphere_radius;
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis products.
    // ------------------------------------------------------------------
    logic signed [P2-1:0] m_esps2_reg [3];
    logic signed [P2-1:0] m_esps2_next [3];
    logic signed [P2-1:0] m_esep2_reg [3];
    logic signed [P2-1:0] m_esep2_next [3];
    logic signed [P2-1:0] m_eses2_reg [3];
    logic signed [P2-1:0] m_eses2_next [3];
    logic signed [P2-1:0] m_psps2_reg [3];
    logic signed [P2-1:0] m_psps2_next [3];
    logic [RW-1:0]        rr2_reg;
    logic [RW-1:0]        rr2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_esps2_next[i] = P2'(es1_reg[i]) * P2'(ps1_reg[i]);
            m_esep2_next[i] = P2'(es1_reg[i]) * P2'(ep1_reg[i]);
            m_eses2_next[i] = P2'(es1_reg[i]) * P2'(es1_reg[i]);
            m_psps2_next[i] = P2'(ps1_reg[i]) * P2'(ps1_reg[i]);
        end
        rr2_next = RW'(r1_reg) * RW'(r1_reg);
    end

    // ------------------------------------------------------------------
    // Stage 3: dot products. a = (E-S).(P-S), b = (S-E).(P-E).
    // ------------------------------------------------------------------
    logic signed [S3-1:0]  a3_reg;
    logic signed [S3-1:0]  a3_next;
    logic signed [S3-1:0]  b3_reg;
    logic signed [S3-1:0]  b3_next;
    logic [W-1:0]          dd3_reg;
    logic [W-1:0]          dd3_next;
    logic signed [WWW-1:0] ww3_reg;
    logic signed [WWW-1:0] ww3_next;
    logic signed [S3-1:0]  dd_sum;
    logic signed [S3-1:0]  pp_sum;

    always_comb
    begin
        a3_next  = S3'(m_esps2_reg[0]) + S3'(m_esps2_reg[1]) + S3'(m_esps2_reg[2]);
        b3_next  = S3'(m_esep2_reg[0]) + S3'(m_esep2_reg[1]) + S3'(m_esep2_reg[2]);
        dd_sum   = S3'(m_eses2_reg[0]) + S3'(m_eses2_reg[1]) + S3'(m_eses2_reg[2]);
        pp_sum   = S3'(m_psps2_reg[0]) + S3'(m_psps2_reg[1]) + S3'(m_psps2_reg[2]);
        dd3_next = dd_sum[W-1:0];
        ww3_next = WWW'(pp_sum) - WWW'(rr2_reg);
    end

    // ------------------------------------------------------------------
    // Stage 4: end test and magnitudes for the discriminant compare.
    // The sign of |P-S|^2 - |P-E|^2 equals the sign of a - b.
    // ------------------------------------------------------------------
    logic                 rej4_reg;
    logic                 rej4_next;
    logic [W-1:0]         amag4_reg;
    logic [W-1:0]         amag4_next;
    logic [W-1:0]         dd4_reg;
    logic [W-1:0]         dd4_next;
    logic                 wwneg4_reg;
    logic                 wwneg4_next;
    logic [W-1:0]         wwmag4_reg;
    logic [W-1:0]         wwmag4_next;
    logic signed [S3-1:0] a_neg;

    always_comb
    begin
        a_neg       = -a3_reg;
        rej4_next   = ((a3_reg < b3_reg) && a3_reg[S3-1])
                    || ((a3_reg > b3_reg) && b3_reg[S3-1]);
        amag4_next  = a3_reg[S3-1] ? a_neg[W-1:0] : a3_reg[W-1:0];
        dd4_next    = dd3_reg;
        wwneg4_next = ww3_reg[WWW-1];
        wwmag4_next = ww3_reg[W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 5: limb partial products of a*a and dd*ww.
    // ------------------------------------------------------------------
    logic [2*L-1:0] aa_ll5_reg;
    logic [2*L-1:0] aa_ll5_next;
    logic [2*L-1:0] aa_lh5_reg;
    logic [2*L-1:0] aa_lh5_next;
    logic [2*L-1:0] aa_hh5_reg;
    logic [2*L-1:0] aa_hh5_next;
    logic [2*L-1:0] dw_ll5_reg;
    logic [2*L-1:0] dw_ll5_next;
    logic [2*L-1:0] dw_lh5_reg;
    logic [2*L-1:0] dw_lh5_next;
    logic [2*L-1:0] dw_hl5_reg;
    logic [2*L-1:0] dw_hl5_next;
    logic [2*L-1:0] dw_hh5_reg;
    logic [2*L-1:0] dw_hh5_next;
    logic           rej5_reg;
    logic           rej5_next;
    logic           wwneg5_reg;
    logic           wwneg5_next;

    always_comb
    begin
        aa_ll5_next = (2*L)'(amag4_reg[L-1:0]) * (2*L)'(amag4_reg[L-1:0]);
        aa_lh5_next = (2*L)'(amag4_reg[L-1:0]) * (2*L)'(amag4_reg[W-1:L]);
        aa_hh5_next = (2*L)'(amag4_reg[W-1:L]) * (2*L)'(amag4_reg[W-1:L]);
        dw_ll5_next = (2*L)'(dd4_reg[L-1:0])   * (2*L)'(wwmag4_reg[L-1:0]);
        dw_lh5_next = (2*L)'(dd4_reg[L-1:0])   * (2*L)'(wwmag4_reg[W-1:L]);
        dw_hl5_next = (2*L)'(dd4_reg[W-1:L])   * (2*L)'(wwmag4_reg[L-1:0]);
        dw_hh5_next = (2*L)'(dd4_reg[W-1:L])   * (2*L)'(wwmag4_reg[W-1:L]);
        rej5_next   = rej4_reg;
        wwneg5_next = wwneg4_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: recombine the limbs into the full products.
    // ------------------------------------------------------------------
    logic [2*W-1:0] sq6_reg;
    logic [2*W-1:0] sq6_next;
    logic [2*W-1:0] pr6_reg;
    logic [2*W-1:0] pr6_next;
    logic           rej6_reg;
    logic           rej6_next;
    logic           wwneg6_reg;
    logic           wwneg6_next;

    always_comb
    begin
        // The cross term of a square appears twice, hence the extra shift.
        sq6_next    = {aa_hh5_reg, aa_ll5_reg} + ((2*W)'(aa_lh5_reg) << (L + 1));
        pr6_next    = {dw_hh5_reg, dw_ll5_reg} + ((2*W)'(dw_lh5_reg) << L)
                    + ((2*W)'(dw_hl5_reg) << L);
        rej6_next   = rej5_reg;
        wwneg6_next = wwneg5_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: output register. A negative ww makes the discriminant positive.
    // ------------------------------------------------------------------
    logic hit_reg;
    logic hit_next;

    assign hit_next = !rej6_reg && (wwneg6_reg || (sq6_reg >= pr6_reg));
    assign hit      = hit_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            ps1_reg <= ps1_next;
            ep1_reg <= ep1_next;
            es1_reg <= es1_next;
            r1_reg  <= r1_next;
        end
        if (adv[2])
        begin
            m_esps2_reg <= m_esps2_next;
            m_esep2_reg <= m_esep2_next;
            m_eses2_reg <= m_eses2_next;
            m_psps2_reg <= m_psps2_next;
            rr2_reg     <= rr2_next;
        end
        if (adv[3])
        begin
            a3_reg  <= a3_next;
            b3_reg  <= b3_next;
            dd3_reg <= dd3_next;
            ww3_reg <= ww3_next;
        end
        if (adv[4])
        begin
            rej4_reg   <= rej4_next;
            amag4_reg  <= amag4_next;
            dd4_reg    <= dd4_next;
            wwneg4_reg <= wwneg4_next;
            wwmag4_reg <= wwmag4_next;
        end
        if (adv[5])
        begin
            aa_ll5_reg <= aa_ll5_next;
            aa_lh5_reg <= aa_lh5_next;
            aa_hh5_reg <= aa_hh5_next;
            dw_ll5_reg <= dw_ll5_next;
            dw_lh5_reg <= dw_lh5_next;
            dw_hl5_reg <= dw_hl5_next;
            dw_hh5_reg <= dw_hh5_next;
            rej5_reg   <= rej5_next;
            wwneg5_reg <= wwneg5_next;
        end
        if (adv[6])
        begin
            sq6_reg    <= sq6_next;
            pr6_reg    <= pr6_next;
            rej6_reg   <= rej6_next;
            wwneg6_reg <= wwneg6_next;
        end
        if (adv[7])
            hit_reg <= hit_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SSHT_ASSERT_NOW(a_full_when_blocked, !in_ready, (&v_reg))
    `SSHT_ASSERT_NOW(a_zero_wall_dots, v_reg[3] && (dd3_reg == '0),
        (a3_reg == '0) && (b3_reg == '0))
    `SSHT_ASSERT_NEXT(a_reject_gives_miss, v_reg[6] && adv[7] && rej6_reg,
        out_valid && !hit)
    `SSHT_ASSERT_NEXT(a_inside_gives_hit, v_reg[6] && adv[7] && !rej6_reg && wwneg6_reg,
        out_valid && hit)

endmodule
